[rtl/pli_pkg.sv]
// Package for the positional list: capacity, widths, operation codes and
// the control bundle that the top level broadcasts to every storage cell.
// No dependencies.
`default_nettype none

package pli_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int KIND_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [IDX_W-1:0] pos_idx;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/pli_cell.sv]
// One storage cell of the positional list: holds one entry and takes its
// left or right neighbor's entry when the list shifts. Uses pli_pkg.
`default_nettype none

module pli_cell
  import pli_pkg::*;
(
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic        [IDX_W-1:0]  idx,
  input  wire logic signed [DATA_W-1:0] new_value,
  input  wire logic signed [DATA_W-1:0] left_data,
  input  wire logic signed [DATA_W-1:0] right_data,
  output logic signed      [DATA_W-1:0] data,
  output logic signed      [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     at_pos;
  logic                     past_pos;

  assign at_pos   = (idx == ctl.pos_idx);
  assign past_pos = (idx >  ctl.pos_idx);

  always_comb begin
    data_nxt = data_r;
    priority if (ctl.ins && at_pos) begin
      data_nxt = new_value;
    end else if (ctl.ins && past_pos) begin
      data_nxt = left_data;
    end else if (ctl.del && (at_pos || past_pos)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (ctl.rd && at_pos) ? data_r : '0;

endmodule

`default_nettype wire

[rtl/positional_list_insert_delete.sv]
// Top level of the positional list: a row of pli_cell storage cells, the
// length counter, command decode and the registered result.
// Uses pli_pkg and pli_cell.
`default_nettype none

// Channel   | Ports                                        | Handshake
// ----------+----------------------------------------------+---------------------------
// command   | in_kind, in_position, in_value               | start high, busy low
// result    | out_read_value, out_list_length, out_error   | out_valid, one-cycle strobe
//
// The whole row of cells shifts in parallel at the accepting edge, and the
// result strobes on the next cycle. Out of reset busy stays low, so a
// command may be taken on every cycle. Reset (rst_n low, synchronous)
// raises busy, empties the list and drops the strobe; cell contents are
// left as they are and only entries below the length are ever read. The
// receiver cannot stall, so no result is ever held.

module positional_list_insert_delete
  import pli_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [KIND_W-1:0] in_kind,
  input  wire logic        [POS_W-1:0]  in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed      [DATA_W-1:0] out_read_value,
  output logic             [LEN_W-1:0]  out_list_length,
  output logic                          out_error
);

  logic                     accept;
  logic [LEN_W:0]           count_ext;
  logic [LEN_W:0]           pos_ext;
  logic                     pos_nonzero;
  logic                     ins_ok;
  logic                     acc_ok;
  logic [POS_W-1:0]         pos_m1;
  cell_ctl_t                ctl;
  logic                     err;
  logic [LEN_W-1:0]         count_r;
  logic [LEN_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic [LEN_W-1:0]         out_list_length_r;
  logic                     out_error_r;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
  logic signed [DATA_W-1:0] rd_value;

  // One transaction per cycle; hold off the sender only under reset.
  assign busy   = !rst_n;
  assign accept = start && !busy;

  assign count_ext   = {1'b0, count_r};
  assign pos_ext     = {1'b0, in_position};
  assign pos_nonzero = (in_position != '0);
  assign pos_m1      = in_position - POS_W'(1);

  // Insert: position 1..length+1 and room left. Delete/read: 1..length.
  assign ins_ok = pos_nonzero && (pos_ext <= count_ext + (LEN_W+1)'(1)) &&
                  (count_r < LEN_W'(CAPACITY));
  assign acc_ok = pos_nonzero && (pos_ext <= count_ext);

  // Decode the command into the cell broadcast, the new length and the flag.
  always_comb begin
    ctl         = '0;
    ctl.pos_idx = pos_m1[IDX_W-1:0];
    count_nxt   = count_r;
    err         = 1'b1;
    unique case (kind_t'(in_kind))
      KIND_INSERT: begin
        err     = !ins_ok;
        ctl.ins = accept && ins_ok;
        if (ctl.ins) begin
          count_nxt = count_r + LEN_W'(1);
        end
      end
      KIND_DELETE: begin
        err     = !acc_ok;
        ctl.del = accept && acc_ok;
        if (ctl.del) begin
          count_nxt = count_r - LEN_W'(1);
        end
      end
      KIND_READ: begin
        err    = !acc_ok;
        ctl.rd = acc_ok;
      end
      default: begin
        err = 1'b1;
      end
    endcase
  end

  // Row of cells: each takes its left neighbor on insert, its right on delete.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end

    pli_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (IDX_W'(i)),
      .new_value  (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero read value; OR them together.
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | cell_rd[i];
    end
  end

  // Clear the length and the strobe under reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= accept ? count_nxt : count_r;
      out_valid_r <= accept;
    end
  end

  // Result payload: advance on every accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r  <= rd_value;
      out_list_length_r <= count_nxt;
      out_error_r       <= err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_list_length = out_list_length_r;
  assign out_error       = out_error_r;

endmodule

`default_nettype wire

[tb/tb_positional_list_insert_delete.sv]
// Testbench for positional_list_insert_delete: directed table, then random
// insert/delete/read traffic checked against a behavioral list predictor.
// Depends on pli_pkg and the positional_list_insert_delete RTL.
`default_nettype none

module tb_positional_list_insert_delete
  import pli_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Kind code that the block does not define; it must be refused.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

  localparam int RANDOM_COMMANDS = 1650;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;

  // One result of the list, field for field as it leaves the block.
  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic [LEN_W-1:0]  len;
    logic              err;
  } list_result_t;

  // One row of the directed table. reps repeats the command with the value
  // bumped by one each time; typed rows carry a hand-written expectation.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [7:0]        reps;
    logic              typed;
    list_result_t      exp;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [KIND_W-1:0] in_kind = '0;
  logic [POS_W-1:0] in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  wire logic busy;
  wire logic out_valid;
  wire logic signed [DATA_W-1:0] out_read_value;
  wire logic [LEN_W-1:0] out_list_length;
  wire logic out_error;

  // Side band that travels with each command: a hand-written expectation.
  logic row_typed = 1'b0;
  list_result_t row_exp = '0;

  // Predictor state: the list contents and its length.
  logic [DATA_W-1:0] list_mem [CAPACITY];
  int list_len = 0;

  list_result_t pending_results[$];
  cmd_row_t directed_rows[$];

  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int n_insert = 0, n_delete = 0, n_read = 0, n_unused = 0;
  int n_refused = 0, n_full_refused = 0, max_len_seen = 0;

  positional_list_insert_delete uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_list_length (out_list_length),
    .out_error       (out_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the predicted list and return the result the block
  // should strobe for it. Refused commands leave the list alone and report
  // the unchanged length with a zero read value.
  function automatic list_result_t apply_list_command(input logic [KIND_W-1:0] kind,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [DATA_W-1:0] val);
    list_result_t res;
    int p;
    int i;
    p = pos;
    res.rd = '0;
    res.err = 1'b1;
    case (kind)
      KIND_INSERT: begin
        if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
          // Shift the tail back one slot, then drop the value in place.
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
          res.err = 1'b0;
        end
      end
      KIND_DELETE: begin
        if (p >= 1 && p <= list_len) begin
          // Pull everything after the removed entry forward one slot.
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          res.err = 1'b0;
        end
      end
      KIND_READ: begin
        if (p >= 1 && p <= list_len) begin
          res.rd = list_mem[p-1];
          res.err = 1'b0;
        end
      end
      default: ;
    endcase
    res.len = list_len[LEN_W-1:0];
    return res;
  endfunction

  // Monitor: retire the strobed result first, then predict the transaction
  // that this same edge accepts. A result is registered, so it always trails
  // its command and the oldest expectation is the one to match.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t pred;
    if (out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result strobed with nothing expected: rd=%0h len=%0d err=%0b",
               out_read_value, out_list_length, out_error);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_value !== want.rd) begin
          $error("out_read_value: expected %0h, got %0h", want.rd, out_read_value);
          mismatches++;
        end
        if (out_list_length !== want.len) begin
          $error("out_list_length: expected %0d, got %0d", want.len, out_list_length);
          mismatches++;
        end
        if (out_error !== want.err) begin
          $error("out_error: expected %0b, got %0b", want.err, out_error);
          mismatches++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      case (in_kind)
        KIND_INSERT: n_insert++;
        KIND_DELETE: n_delete++;
        KIND_READ:   n_read++;
        default:     n_unused++;
      endcase
      if (in_kind == KIND_INSERT && list_len == CAPACITY) n_full_refused++;
      pred = apply_list_command(in_kind, in_position, in_value);
      if (pred.err) n_refused++;
      if (list_len > max_len_seen) max_len_seen = list_len;
      // Typed rows stand on their own expectation; the predictor still
      // advances so later rows see the right list.
      pending_results.push_back(row_typed ? row_exp : pred);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one command at the falling edge and hold it until the block
  // takes it. Between bursts, sometimes drop start for a random gap.
  task automatic send_command(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val, input logic typed,
                              input list_result_t exp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= val;
    row_typed   <= typed;
    row_exp     <= exp;
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  task automatic add_row(input logic [KIND_W-1:0] kind, input int pos,
                         input logic [DATA_W-1:0] val, input int reps, input logic typed,
                         input logic [DATA_W-1:0] rd, input int len, input logic err);
    cmd_row_t row;
    row.kind = kind;
    row.pos = pos[POS_W-1:0];
    row.val = val;
    row.reps = reps[7:0];
    row.typed = typed;
    row.exp.rd = rd;
    row.exp.len = len[LEN_W-1:0];
    row.exp.err = err;
    directed_rows.push_back(row);
  endtask

  initial begin
    int r;
    int k;
    int sel;
    int hi;
    logic fill_mode;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0] pos;
    logic [DATA_W-1:0] val;
    cmd_row_t row;

    for (k = 0; k < CAPACITY; k++) list_mem[k] = '0;

    // Empty list: every access is refused, including insert past the end.
    add_row(KIND_READ,   1, 0, 1, 1, 0, 0, 1);
    add_row(KIND_DELETE, 1, 0, 1, 1, 0, 0, 1);
    add_row(KIND_INSERT, 0, 0, 1, 1, 0, 0, 1);
    add_row(KIND_INSERT, 2, 0, 1, 1, 0, 0, 1);
    // Build a three-entry list out of the value extremes: head, head, tail.
    add_row(KIND_INSERT, 1, VAL_MAX,  1, 1, 0, 1, 0);
    add_row(KIND_INSERT, 1, VAL_MIN,  1, 1, 0, 2, 0);
    add_row(KIND_INSERT, 3, VAL_NEG1, 1, 1, 0, 3, 0);
    add_row(KIND_READ,   1, 0, 1, 1, VAL_MIN,  3, 0);
    add_row(KIND_READ,   3, 0, 1, 1, VAL_NEG1, 3, 0);
    add_row(KIND_READ,   0, 0, 1, 1, 0, 3, 1);
    add_row(KIND_READ,  31, 0, 1, 1, 0, 3, 1);
    add_row(KIND_UNUSED, 1, VAL_MAX, 1, 1, 0, 3, 1);
    // Middle insert, tail delete, bad deletes, head delete.
    add_row(KIND_INSERT, 2, 0, 1, 1, 0, 4, 0);
    add_row(KIND_DELETE, 4, 0, 1, 1, 0, 3, 0);
    add_row(KIND_DELETE, 0, 0, 1, 1, 0, 3, 1);
    add_row(KIND_DELETE, 31, 0, 1, 1, 0, 3, 1);
    add_row(KIND_DELETE, 1, 0, 1, 1, 0, 2, 0);
    add_row(KIND_READ,   1, 0, 1, 0, 0, 0, 0);
    add_row(KIND_READ,   2, 0, 1, 0, 0, 0, 0);
    // Fill to capacity at the head, then hit the full-list refusals.
    add_row(KIND_INSERT, 1, 32'h5A5A_0000, CAPACITY - 2, 0, 0, 0, 0);
    add_row(KIND_INSERT, 1, 32'h1234_5678, 1, 1, 0, CAPACITY, 1);
    add_row(KIND_INSERT, CAPACITY + 1, 0, 1, 1, 0, CAPACITY, 1);
    add_row(KIND_READ,   CAPACITY, 0, 1, 1, VAL_MAX, CAPACITY, 0);
    add_row(KIND_DELETE, CAPACITY, 0, 1, 1, 0, CAPACITY - 1, 0);
    add_row(KIND_INSERT, CAPACITY, VAL_MIN, 1, 0, 0, 0, 0);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (r = 0; r < row.reps; r++)
        send_command(row.kind, row.pos, row.val + r, row.typed, row.exp);
    end

    // Random traffic: alternate fill and drain phases so the list sweeps
    // between empty and full; most positions are legal, a tenth are noise.
    fill_mode = 1'b1;
    for (k = 0; k < RANDOM_COMMANDS; k++) begin
      if (fill_mode && list_len == CAPACITY && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
      if (!fill_mode && list_len == 0 && $urandom_range(0, 3) == 0) fill_mode = 1'b1;
      if ($urandom_range(0, 63) == 0) fill_mode = !fill_mode;

      sel = $urandom_range(0, 99);
      if (sel < 2)                         kind = KIND_UNUSED;
      else if (sel < (fill_mode ? 60 : 25)) kind = KIND_INSERT;
      else if (sel < (fill_mode ? 80 : 75)) kind = KIND_DELETE;
      else                                 kind = KIND_READ;

      hi = (kind == KIND_INSERT) ? list_len + 1 : list_len;
      if ($urandom_range(0, 9) == 0 || kind == KIND_UNUSED || hi < 1)
        pos = POS_W'($urandom_range(0, 31));
      else
        pos = POS_W'($urandom_range(1, hi));

      case ($urandom_range(0, 15))
        0:       val = VAL_MAX;
        1:       val = VAL_MIN;
        2:       val = VAL_NEG1;
        3:       val = '0;
        default: val = $urandom;
      endcase

      send_command(kind, pos, val, 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;

    // Let the last results land, then watch a little longer for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d inserts, %0d deletes, %0d reads, %0d unused-kind commands.",
             n_insert, n_delete, n_read, n_unused);
    $display("%0d refused, %0d of them on a full list; peak length %0d, %0d mismatches.",
             n_refused, n_full_refused, max_len_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
